### rtl/msc_pkg.sv
// Shared types, constants and segment tables for the marching-squares contour stream.
package msc_pkg;

    // Field widths fixed by the stream formats.
    localparam int RED_W    = 8;
    localparam int COORD_W  = 13;
    localparam int CASE_W   = 4;
    localparam int STEP_W   = 5;
    localparam int PHASE_W  = 4;
    localparam int SIZE_W   = 12;
    localparam int ROW_W    = 11;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 2;

    // Limits of the grid geometry.
    localparam int MSC_MAX_WIDTH = 2048;
    localparam int ROW_LIMIT     = 2048;
    localparam int STEP_LIMIT    = 16;
    localparam int SIZE_MIN      = 2;
    localparam int CFG_WIDTH_MAX = 4095;

    // Depth of the segment queue; must be a power of two.
    localparam int MSC_QUEUE_DEPTH = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_STEP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd3;

    // Configuration reset values.
    localparam logic [RED_W-1:0]  THRESHOLD_RST = 8'd127;
    localparam logic [STEP_W-1:0] STEP_RST      = 5'd7;
    localparam logic [SIZE_W-1:0] WIDTH_RST     = 12'd640;
    localparam logic [SIZE_W-1:0] HEIGHT_RST    = 12'd480;

    // Edge midpoints of a cell.
    localparam logic [1:0] PT_LEFT   = 2'd0;
    localparam logic [1:0] PT_TOP    = 2'd1;
    localparam logic [1:0] PT_RIGHT  = 2'd2;
    localparam logic [1:0] PT_BOTTOM = 2'd3;

    typedef struct packed {
        logic [RED_W-1:0] red_value;
        logic             frame_start;
    } pixel_t;

    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [CASE_W-1:0]  cell_case;
        logic               last_segment;
    } segment_t;

    // What the segment decoder hands back for one cell.
    typedef struct packed {
        logic [1:0] count;
        segment_t   first;
        segment_t   second;
    } seg_pair_t;

    // Number of segments that a corner code produces.
    function automatic logic [1:0] seg_count(input logic [CASE_W-1:0] cs);
        logic [1:0] n;
        case (cs)
            4'd0, 4'd15: n = 2'd0;
            4'd5, 4'd10: n = 2'd2;
            default:     n = 2'd1;
        endcase
        return n;
    endfunction

    // Endpoints {first start, first end, second start, second end}.
    function automatic logic [7:0] seg_ends(input logic [CASE_W-1:0] cs);
        logic [7:0] e;
        case (cs)
            4'd1, 4'd14: e = {PT_LEFT,  PT_BOTTOM, PT_LEFT, PT_LEFT};
            4'd2, 4'd13: e = {PT_RIGHT, PT_BOTTOM, PT_LEFT, PT_LEFT};
            4'd3, 4'd12: e = {PT_LEFT,  PT_RIGHT,  PT_LEFT, PT_LEFT};
            4'd4, 4'd11: e = {PT_TOP,   PT_RIGHT,  PT_LEFT, PT_LEFT};
            4'd5:        e = {PT_LEFT,  PT_TOP,    PT_RIGHT, PT_BOTTOM};
            4'd6, 4'd9:  e = {PT_TOP,   PT_BOTTOM, PT_LEFT, PT_LEFT};
            4'd7, 4'd8:  e = {PT_LEFT,  PT_TOP,    PT_LEFT, PT_LEFT};
            4'd10:       e = {PT_LEFT,  PT_BOTTOM, PT_TOP,  PT_RIGHT};
            default:     e = {PT_LEFT,  PT_LEFT,   PT_LEFT, PT_LEFT};
        endcase
        return e;
    endfunction

endpackage

### rtl/msc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module msc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/msc_seg.sv
// Segment decoder: turns a cell's corner code and origin into up to two segments.
module msc_seg
    import msc_pkg::*;
(
    input  logic [CASE_W-1:0]  cell_case,
    input  logic [COORD_W-1:0] x_base,
    input  logic [COORD_W-1:0] y_base,
    input  logic [STEP_W-1:0]  step,
    output seg_pair_t          pair
);

    logic [COORD_W-1:0] s1;
    logic [COORD_W-1:0] s2;
    logic [7:0]         ends;
    logic [1:0]         n;

    // Midpoint of one cell edge, in half-pixel units, wrapping at 13 bits.
    function automatic logic [2*COORD_W-1:0] midpoint(
        input logic [1:0]         code,
        input logic [COORD_W-1:0] xb,
        input logic [COORD_W-1:0] yb,
        input logic [COORD_W-1:0] h,
        input logic [COORD_W-1:0] f
    );
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        case (code)
            PT_LEFT:  begin px = xb;     py = yb + h; end
            PT_TOP:   begin px = xb + h; py = yb;     end
            PT_RIGHT: begin px = xb + f; py = yb + h; end
            default:  begin px = xb + h; py = yb + f; end
        endcase
        return {px, py};
    endfunction

    assign s1   = COORD_W'(step);
    assign s2   = COORD_W'({step, 1'b0});
    assign ends = seg_ends(cell_case);
    assign n    = seg_count(cell_case);

    always_comb
    begin
        pair.count = n;
        {pair.first.start_x, pair.first.start_y}   = midpoint(ends[7:6], x_base, y_base, s1, s2);
        {pair.first.end_x, pair.first.end_y}       = midpoint(ends[5:4], x_base, y_base, s1, s2);
        pair.first.cell_case                       = cell_case;
        pair.first.last_segment                    = (n == 2'd1);
        {pair.second.start_x, pair.second.start_y} = midpoint(ends[3:2], x_base, y_base, s1, s2);
        {pair.second.end_x, pair.second.end_y}     = midpoint(ends[1:0], x_base, y_base, s1, s2);
        pair.second.cell_case                      = cell_case;
        pair.second.last_segment                   = 1'b1;
    end

endmodule

### rtl/marching_squares_contour_stream.sv
// Top level of the marching-squares contour stream: grid sampling, line buffer and segment queue.
//
//   channel   direction  handshake                 beat
//   pixel     in         pixel_valid/pixel_ready   pixel_t: red_value, frame_start
//   segment   out        seg_valid/seg_ready       segment_t: endpoints, cell_case, last_segment
//   cfg       in         cfg_write (no wait)       cfg_index selects, cfg_data carries value
//
// A pixel beat is taken into the input register and handled there once the segment
// queue has room; its segments are written into the queue, which offers them on the output.
// The block takes one pixel beat per cycle while the queue has room; the pace is set
// by the four-entry segment queue, which must hold two free entries before a pixel
// leaves the input register. A two-segment cell pushes both at once, absorbed by the queue.
// Reset clears the counters, phases, left bits, queue and input register; the line
// buffer RAM holds no reset and every entry is written before a sampled row reads it.
// Stalls on the segment side fill the queue and then hold pixel_ready low.
module marching_squares_contour_stream
    import msc_pkg::*;
#(
    parameter int MAX_WIDTH = MSC_MAX_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pixel_valid,
    output logic                 pixel_ready,
    input  pixel_t               pixel,
    output logic                 seg_valid,
    input  logic                 seg_ready,
    output segment_t             segment,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // Sample column indexes the line buffer; the pixel column only has to reach the
    // widest image the width register can ask for under this MAX_WIDTH.
    localparam int SCOL_W = $clog2(MAX_WIDTH);
    localparam int WMAX   = (MAX_WIDTH < CFG_WIDTH_MAX) ? MAX_WIDTH : CFG_WIDTH_MAX;
    localparam int PCOL_W = $clog2(WMAX);
    localparam int QPTR_W = $clog2(MSC_QUEUE_DEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    // Configuration registers.
    logic [RED_W-1:0]  threshold_reg;
    logic [STEP_W-1:0] cell_step_reg;
    logic [SIZE_W-1:0] image_width_reg;
    logic [SIZE_W-1:0] image_height_reg;

    // Input register.
    logic   pix_valid_reg;
    pixel_t pix_reg;

    // Raster and grid state.
    logic [PCOL_W-1:0]  pixel_column_reg, pixel_column_next;
    logic [ROW_W-1:0]   pixel_row_reg, pixel_row_next;
    logic [PHASE_W-1:0] column_phase_reg, column_phase_next;
    logic [PHASE_W-1:0] row_phase_reg, row_phase_next;
    logic [SCOL_W-1:0]  sample_column_reg, sample_column_next;
    logic [ROW_W-1:0]   sample_row_reg, sample_row_next;
    logic               left_bit_reg, left_bit_next;
    logic               left_above_bit_reg, left_above_bit_next;

    // Line buffer forwarding and the mirror of entry zero.
    logic fwd_hit_reg;
    logic fwd_bit_reg;
    logic col0_bit_reg;
    logic ram_bit;

    // Segment queue.
    segment_t           queue_reg [MSC_QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    // Working signals.
    logic               consume;
    logic               pop;
    logic [STEP_W-1:0]  step;
    logic [SIZE_W-1:0]  width;
    logic [SIZE_W-1:0]  height;
    logic               fs;
    logic [PCOL_W-1:0]  pc_eff;
    logic [ROW_W-1:0]   pr_eff;
    logic [PHASE_W-1:0] cp_eff;
    logic [PHASE_W-1:0] rp_eff;
    logic [SCOL_W-1:0]  sc_eff;
    logic [ROW_W-1:0]   sr_eff;
    logic               lb_eff;
    logic               lab_eff;
    logic               sample;
    logic               solid;
    logic               above;
    logic               make_cell;
    logic [CASE_W-1:0]  cs;
    logic [COORD_W-1:0] x_base;
    logic [COORD_W-1:0] y_base;
    logic               row_end;
    logic               frame_end;
    seg_pair_t          pair;
    logic [1:0]         push_n;

    // ---------------------------------------------------------------------
    // Configuration port. Writes should land only while the block is idle; it does not enforce this.
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= THRESHOLD_RST;
            cell_step_reg    <= STEP_RST;
            image_width_reg  <= WIDTH_RST;
            image_height_reg <= HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD:    threshold_reg    <= cfg_data[RED_W-1:0];
                CFG_CELL_STEP:    cell_step_reg    <= cfg_data[STEP_W-1:0];
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[SIZE_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[SIZE_W-1:0];
            endcase
        end
    end

    // Clamped geometry: step in 1..16, sizes at least two and at most their limits.
    always_comb
    begin
        if (cell_step_reg == '0)
            step = STEP_W'(1);
        else if (32'(cell_step_reg) > STEP_LIMIT)
            step = STEP_W'(STEP_LIMIT);
        else
            step = cell_step_reg;

        if (32'(image_width_reg) < SIZE_MIN)
            width = SIZE_W'(SIZE_MIN);
        else if (32'(image_width_reg) > MAX_WIDTH)
            width = SIZE_W'(MAX_WIDTH);
        else
            width = image_width_reg;

        if (32'(image_height_reg) < SIZE_MIN)
            height = SIZE_W'(SIZE_MIN);
        else if (32'(image_height_reg) > ROW_LIMIT)
            height = SIZE_W'(ROW_LIMIT);
        else
            height = image_height_reg;
    end

    // ---------------------------------------------------------------------
    // Handshakes. A pixel leaves the input register only when the queue has
    // room for two segments, so pixel_ready depends on registers alone.
    // ---------------------------------------------------------------------
    assign consume     = pix_valid_reg && (32'(count_reg) <= MSC_QUEUE_DEPTH - 2);
    assign pixel_ready = !pix_valid_reg || consume;
    assign seg_valid   = (count_reg != '0);
    assign pop         = seg_valid && seg_ready;
    assign segment     = queue_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
        end
        else if (pixel_ready)
        begin
            pix_valid_reg <= pixel_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_ready && pixel_valid)
        begin
            pix_reg <= pixel;
        end
    end

    // ---------------------------------------------------------------------
    // Sampling. A frame start clears the counters before the pixel is used.
    // ---------------------------------------------------------------------
    assign fs      = pix_reg.frame_start;
    assign pc_eff  = fs ? '0 : pixel_column_reg;
    assign pr_eff  = fs ? '0 : pixel_row_reg;
    assign cp_eff  = fs ? '0 : column_phase_reg;
    assign rp_eff  = fs ? '0 : row_phase_reg;
    assign sc_eff  = fs ? '0 : sample_column_reg;
    assign sr_eff  = fs ? '0 : sample_row_reg;
    assign lb_eff  = fs ? 1'b0 : left_bit_reg;
    assign lab_eff = fs ? 1'b0 : left_above_bit_reg;

    // A sample must leave a full step of pixels to its right and below.
    assign sample = (cp_eff == '0) && (rp_eff == '0)
                 && (13'(pc_eff) + 13'(step) <= 13'(width))
                 && (13'(pr_eff) + 13'(step) <= 13'(height));

    assign solid = (pix_reg.red_value <= threshold_reg);

    // The line buffer bit for the current column. The RAM was addressed with
    // this column in the previous cycle; a write to the same entry in that cycle is
    // forwarded, and a frame start reads the mirrored entry zero.
    always_comb
    begin
        if (fs)
            above = col0_bit_reg;
        else if (fwd_hit_reg)
            above = fwd_bit_reg;
        else
            above = ram_bit;
    end

    assign make_cell = sample && (sc_eff != '0) && (sr_eff != '0);
    assign cs        = {lab_eff, above, solid, lb_eff};

    // Top-left pixel of the cell in half-pixel units, wrapping at 13 bits.
    assign x_base = COORD_W'({13'(pc_eff) - 13'(step), 1'b0});
    assign y_base = COORD_W'({13'(pr_eff) - 13'(step), 1'b0});

    msc_seg u_seg (
        .cell_case (cs),
        .x_base    (x_base),
        .y_base    (y_base),
        .step      (step),
        .pair      (pair)
    );

    assign push_n = (consume && make_cell) ? pair.count : 2'd0;

    // ---------------------------------------------------------------------
    // Counter advance.
    // ---------------------------------------------------------------------
    assign row_end   = (13'(pc_eff) + 13'd1 >= 13'(width));
    assign frame_end = (12'(pr_eff) + 12'd1 >= height);

    always_comb
    begin
        pixel_column_next   = pixel_column_reg;
        pixel_row_next      = pixel_row_reg;
        column_phase_next   = column_phase_reg;
        row_phase_next      = row_phase_reg;
        sample_column_next  = sample_column_reg;
        sample_row_next     = sample_row_reg;
        left_bit_next       = left_bit_reg;
        left_above_bit_next = left_above_bit_reg;

        if (consume)
        begin
            pixel_column_next   = pc_eff;
            pixel_row_next      = pr_eff;
            column_phase_next   = cp_eff;
            row_phase_next      = rp_eff;
            sample_column_next  = sc_eff;
            sample_row_next     = sr_eff;
            left_bit_next       = lb_eff;
            left_above_bit_next = lab_eff;

            if (sample)
            begin
                left_bit_next       = solid;
                left_above_bit_next = above;
                if (32'(sc_eff) < MAX_WIDTH - 1)
                    sample_column_next = sc_eff + SCOL_W'(1);
            end

            if (row_end)
            begin
                pixel_column_next  = '0;
                column_phase_next  = '0;
                sample_column_next = '0;
                if ((rp_eff == '0) && (32'(sr_eff) < ROW_LIMIT - 1))
                    sample_row_next = sr_eff + ROW_W'(1);
                if (frame_end)
                begin
                    pixel_row_next  = '0;
                    row_phase_next  = '0;
                    sample_row_next = '0;
                end
                else
                begin
                    pixel_row_next = pr_eff + ROW_W'(1);
                    if (5'(rp_eff) + 5'd1 >= step)
                        row_phase_next = '0;
                    else
                        row_phase_next = rp_eff + PHASE_W'(1);
                end
            end
            else
            begin
                pixel_column_next = pc_eff + PCOL_W'(1);
                if (5'(cp_eff) + 5'd1 >= step)
                    column_phase_next = '0;
                else
                    column_phase_next = cp_eff + PHASE_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_column_reg   <= '0;
            pixel_row_reg      <= '0;
            column_phase_reg   <= '0;
            row_phase_reg      <= '0;
            sample_column_reg  <= '0;
            sample_row_reg     <= '0;
            left_bit_reg       <= 1'b0;
            left_above_bit_reg <= 1'b0;
        end
        else
        begin
            pixel_column_reg   <= pixel_column_next;
            pixel_row_reg      <= pixel_row_next;
            column_phase_reg   <= column_phase_next;
            row_phase_reg      <= row_phase_next;
            sample_column_reg  <= sample_column_next;
            sample_row_reg     <= sample_row_next;
            left_bit_reg       <= left_bit_next;
            left_above_bit_reg <= left_above_bit_next;
        end
    end

    // ---------------------------------------------------------------------
    // Line buffer. The read address is the sample column the next pixel will
    // see, so the registered read data lines up with that pixel.
    // ---------------------------------------------------------------------
    msc_ram #(
        .WIDTH (1),
        .DEPTH (MAX_WIDTH)
    ) u_row_above (
        .clk     (clk),
        .wr_en   (consume && sample),
        .wr_addr (sc_eff),
        .wr_data (solid),
        .rd_addr (sample_column_next),
        .rd_data (ram_bit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= consume && sample && (sc_eff == sample_column_next);
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_bit_reg <= solid;
        if (consume && sample && (sc_eff == '0))
        begin
            col0_bit_reg <= solid;
        end
    end

    // ---------------------------------------------------------------------
    // Segment queue: up to two pushes and one pop per cycle. The pointers
    // wrap on their own because the depth is a power of two.
    // ---------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= pair.first;
        end
        if (push_n == 2'd2)
        begin
            queue_reg[wr_ptr_reg + QPTR_W'(1)] <= pair.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push_n);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_reg + QCNT_W'(push_n) - QCNT_W'(pop);
        end
    end

`ifndef NO_ASSERTIONS
    // The queue never takes more segments than it has entries.
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= MSC_QUEUE_DEPTH)
        else $error("segment queue overflow");

    // Two segments in one beat only come from the two saddle cases.
    a_saddle_only: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n == 2'd2) |-> ((cs == 4'd5) || (cs == 4'd10)))
        else $error("two segments from a non-saddle cell");

    // Every offered segment belongs to a cell that has a contour.
    a_case_range: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid |-> ((segment.cell_case != 4'd0) && (segment.cell_case != 4'd15)))
        else $error("segment offered for an empty or full cell");

    // A column counter at zero always comes with its phase and sample column at zero.
    a_col_start: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_column_reg == '0) |-> ((column_phase_reg == '0) && (sample_column_reg == '0)))
        else $error("column phase out of step with pixel column");

    // A row counter at zero always comes with its phase and sample row at zero.
    a_row_start: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_row_reg == '0) |-> ((row_phase_reg == '0) && (sample_row_reg == '0)))
        else $error("row phase out of step with pixel row");
`endif

endmodule

### sim/testbench.sv
// Self-checking testbench for the marching-squares contour stream: stimulus, prediction and checks.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import msc_pkg::*;

    // Length of the random part, in pixel beats.
    localparam int RANDOM_PIXELS       = 600;
    // The one long hold-off of the segment receiver, in cycles.
    localparam int SQUEEZE_CYCLES      = 400;
    // Cycles without any accepted beat or register write before the run is declared hung.
    localparam int STALL_LIMIT         = 4000;
    // Cycles allowed for a pixel still in the input register before a register write.
    localparam int SETTLE_CYCLES       = 6;
    // Cycles watched for stray segments once nothing is expected any more.
    localparam int DRAIN_CYCLES        = 20;
    localparam int REPORT_LIMIT        = 10;
    // Width of the rows that fill the line buffer; wider than any random image size.
    localparam int FILL_ROW            = 64;

    // Corner rows for the directed frame, two pixels wide: every ordered pair of
    // consecutive rows appears once, so all sixteen corner codes come out.
    localparam logic [33:0] ROW_PATTERN = 34'b00_00_01_00_10_00_11_01_01_10_01_11_10_10_11_11_00;

    // Predicts the segments of every accepted pixel beat and checks the segment beats in order.
    class contour_scoreboard;
        bit [RED_W-1:0]  threshold;
        bit [STEP_W-1:0] cell_step;
        bit [SIZE_W-1:0] image_width;
        bit [SIZE_W-1:0] image_height;
        bit              row_above [MSC_MAX_WIDTH];
        int unsigned     pix_col, pix_row, col_phase, row_phase, samp_col, samp_row;
        bit              left_bit, left_above;
        segment_t        pending_segments[$];
        int unsigned     pixels_noted, segments_checked, failures;
        bit [15:0]       codes_seen;

        function void power_on();
            threshold    = THRESHOLD_RST;
            cell_step    = STEP_RST;
            image_width  = WIDTH_RST;
            image_height = HEIGHT_RST;
            foreach (row_above[i]) row_above[i] = 1'b0;
            restart_frame();
        endfunction

        function void restart_frame();
            pix_col    = 0;
            pix_row    = 0;
            col_phase  = 0;
            row_phase  = 0;
            samp_col   = 0;
            samp_row   = 0;
            left_bit   = 1'b0;
            left_above = 1'b0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_THRESHOLD:    threshold    = data[RED_W-1:0];
                CFG_CELL_STEP:    cell_step    = data[STEP_W-1:0];
                CFG_IMAGE_WIDTH:  image_width  = data;
                CFG_IMAGE_HEIGHT: image_height = data;
            endcase
        endfunction

        function int unsigned limit(int unsigned v, int unsigned lo, int unsigned hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        // Edge midpoint of a cell whose top-left corner is (x0, y0) in half-pixel units.
        function void midpoint(logic [1:0] which, logic [COORD_W-1:0] x0,
                               logic [COORD_W-1:0] y0, logic [COORD_W-1:0] s,
                               output logic [COORD_W-1:0] px, output logic [COORD_W-1:0] py);
            case (which)
                PT_LEFT:   begin px = x0;                    py = y0 + s;                end
                PT_TOP:    begin px = x0 + s;                py = y0;                    end
                PT_RIGHT:  begin px = COORD_W'(x0 + 2 * s); py = y0 + s;                end
                PT_BOTTOM: begin px = x0 + s;                py = COORD_W'(y0 + 2 * s); end
            endcase
        endfunction

        function void note_pixel(pixel_t beat);
            int unsigned        step, width, height;
            bit                 solid, above;
            logic [CASE_W-1:0]  code;
            logic [3:0]         cut;
            logic [1:0]         pts[$];
            logic [COORD_W-1:0] cx, cy, s;
            segment_t           seg;
            int                 n;

            pixels_noted++;
            step   = limit(cell_step, 1, STEP_LIMIT);
            width  = limit(image_width, SIZE_MIN, MSC_MAX_WIDTH);
            height = limit(image_height, SIZE_MIN, ROW_LIMIT);
            if (beat.frame_start) restart_frame();

            if (col_phase == 0 && row_phase == 0 && pix_col + step <= width &&
                pix_row + step <= height && samp_col < MSC_MAX_WIDTH) begin
                solid = (beat.red_value <= threshold);
                above = row_above[samp_col];
                if (samp_col > 0 && samp_row > 0) begin
                    code = {left_above, above, solid, left_bit};
                    codes_seen[code] = 1'b1;
                    // An edge is crossed where its two corners differ; the crossed edges,
                    // taken in the order left, top, right, bottom, pair up into segments.
                    cut[PT_LEFT]   = left_above ^ left_bit;
                    cut[PT_TOP]    = left_above ^ above;
                    cut[PT_RIGHT]  = above ^ solid;
                    cut[PT_BOTTOM] = left_bit ^ solid;
                    for (int e = 0; e < 4; e++) if (cut[e]) pts.push_back(2'(e));
                    // Saddle with solid top-left: left joins bottom and top joins right.
                    if (pts.size() == 4 && left_above) pts = '{PT_LEFT, PT_BOTTOM, PT_TOP, PT_RIGHT};
                    n  = pts.size() / 2;
                    cx = COORD_W'(2 * (pix_col - step));
                    cy = COORD_W'(2 * (pix_row - step));
                    s  = COORD_W'(step);
                    for (int k = 0; k < n; k++) begin
                        midpoint(pts[2 * k], cx, cy, s, seg.start_x, seg.start_y);
                        midpoint(pts[2 * k + 1], cx, cy, s, seg.end_x, seg.end_y);
                        seg.cell_case    = code;
                        seg.last_segment = (k == n - 1);
                        pending_segments.push_back(seg);
                    end
                end
                left_bit   = solid;
                left_above = above;
                row_above[samp_col] = solid;
                if (samp_col < MSC_MAX_WIDTH - 1) samp_col++;
            end

            if (pix_col + 1 >= width) begin
                pix_col   = 0;
                col_phase = 0;
                samp_col  = 0;
                if (row_phase == 0 && samp_row < ROW_LIMIT - 1) samp_row++;
                if (pix_row + 1 >= height) begin
                    pix_row   = 0;
                    row_phase = 0;
                    samp_row  = 0;
                end
                else begin
                    pix_row++;
                    row_phase = (row_phase + 1 >= step) ? 0 : row_phase + 1;
                end
            end
            else begin
                pix_col++;
                col_phase = (col_phase + 1 >= step) ? 0 : col_phase + 1;
            end
        endfunction

        function void check_segment(segment_t got);
            segment_t want;
            string    diffs;

            segments_checked++;
            if (pending_segments.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("Unexpected segment (%0d,%0d)-(%0d,%0d) case %0d last %0d",
                             got.start_x, got.start_y, got.end_x, got.end_y,
                             got.cell_case, got.last_segment);
                return;
            end
            want  = pending_segments.pop_front();
            diffs = "";
            if (got.start_x !== want.start_x) diffs = {diffs, " start_x"};
            if (got.start_y !== want.start_y) diffs = {diffs, " start_y"};
            if (got.end_x !== want.end_x) diffs = {diffs, " end_x"};
            if (got.end_y !== want.end_y) diffs = {diffs, " end_y"};
            if (got.cell_case !== want.cell_case) diffs = {diffs, " cell_case"};
            if (got.last_segment !== want.last_segment) diffs = {diffs, " last_segment"};
            if (diffs != "") begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display({"Segment %0d differs in%s: expected (%0d,%0d)-(%0d,%0d) case %0d ",
                              "last %0d, got (%0d,%0d)-(%0d,%0d) case %0d last %0d"},
                             segments_checked, diffs, want.start_x, want.start_y,
                             want.end_x, want.end_y, want.cell_case, want.last_segment,
                             got.start_x, got.start_y, got.end_x, got.end_y,
                             got.cell_case, got.last_segment);
            end
        endfunction
    endclass

    // All inputs of the block start from known values at time zero.
    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 pixel_valid = 1'b0;
    pixel_t               pixel       = '0;
    logic                 seg_ready   = 1'b0;
    logic                 cfg_write   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [CFG_W-1:0]     cfg_data    = '0;
    logic                 pixel_ready;
    logic                 seg_valid;
    segment_t             segment;

    contour_scoreboard sb;
    int unsigned       quiet_cycles    = 0;
    // Calm stretches switch off idling on one side for a whole phase.
    bit                sender_calm     = 1'b0;
    bit                receiver_calm   = 1'b0;
    // Set by the stimulus once the block is busy; the receiver then holds off for a long time.
    bit                squeeze_request = 1'b0;
    bit                squeeze_done    = 1'b0;

    marching_squares_contour_stream DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .seg_valid   (seg_valid),
        .seg_ready   (seg_ready),
        .segment     (segment),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #2 clk = ~clk;

    // Length of an idle gap: mostly none or short, now and then a long one.
    function automatic int idle_length(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Sizes are mostly small so that rows turn over quickly; a few are below the minimum.
    function automatic int unsigned pick_size();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return $urandom_range(0, 1);
        if (r == 2) return $urandom_range(32, 48);
        return $urandom_range(2, 24);
    endfunction

    // Random red value; one in five lands right on either side of the threshold.
    function automatic pixel_t random_pixel(bit fs);
        pixel_t beat;
        int     r;
        r = $urandom_range(0, 9);
        if (r == 0) beat.red_value = sb.threshold;
        else if (r == 1) beat.red_value = sb.threshold + 8'd1;
        else beat.red_value = RED_W'($urandom_range(0, 255));
        beat.frame_start = fs;
        return beat;
    endfunction

    // Offers one pixel beat and returns at the edge where it is taken. Valid stays high
    // across back-to-back beats, so it is never lowered and raised in the same step.
    task automatic send_pixel(pixel_t beat);
        int gap;
        gap = idle_length(sender_calm);
        if (gap > 0) begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel       <= beat;
        pixel_valid <= 1'b1;
        do @(posedge clk); while (!pixel_ready);
    endtask

    // Register writes take effect at once; the predictor is updated alongside.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        sb.write_register(idx, CFG_W'(value));
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Brings the block to rest: no pixel offered, every predicted segment delivered, and
    // a settling wait for a pixel that produced nothing but may still be in flight.
    task automatic settle();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_segments.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Beat monitor and hang detector. Both sides are sampled at the rising edge, so the
    // values seen are those the block itself saw at that edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (pixel_valid && pixel_ready) sb.note_pixel(pixel);
            if (seg_valid && seg_ready) sb.check_segment(segment);
            if ((pixel_valid && pixel_ready) || (seg_valid && seg_ready) || cfg_write)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("No beat moved for %0d cycles", STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Segment receiver. It stalls at random, and once, on request, holds off long enough
    // for the segment queue to fill and back up into the pixel side.
    initial begin : segment_sink
        int hold;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (squeeze_request && !squeeze_done) begin
                hold         = SQUEEZE_CYCLES;
                squeeze_done = 1'b1;
            end
            else begin
                hold = idle_length(receiver_calm);
            end
            if (hold > 0) begin
                seg_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            seg_ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial begin : stimulus
        pixel_t      beat;
        bit          solid;
        bit          carry_on;
        int unsigned random_count;
        int unsigned phases;
        int unsigned length;

        sb = new;
        sb.power_on();
        random_count = 0;
        phases       = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A few pixels at the reset settings: the start of row 0 of a wide frame, which
        // must produce nothing.
        for (int i = 0; i < 8; i++) send_pixel(random_pixel(i == 0));
        settle();

        // Directed frame. Step 0 acts as 1, width 0 as 2 and height 4095 as the row limit,
        // so every row is a single cell row under the one above. Solid pixels alternate
        // between 0 and the threshold, empty ones between one above it and 255.
        write_reg(CFG_THRESHOLD, 100);
        write_reg(CFG_CELL_STEP, 0);
        write_reg(CFG_IMAGE_WIDTH, 0);
        write_reg(CFG_IMAGE_HEIGHT, 4095);
        for (int r = 0; r < 17; r++) begin
            for (int c = 0; c < 2; c++) begin
                solid = ROW_PATTERN[33 - 2 * r - c];
                if (solid) beat.red_value = ((r + c) % 2 == 0) ? 8'd0 : sb.threshold;
                else beat.red_value = ((r + c) % 2 == 0) ? 8'd255 : sb.threshold + 8'd1;
                beat.frame_start = (r == 0 && c == 0);
                send_pixel(beat);
            end
        end
        settle();

        // Fill frame: two rows at step 1, wider than any random size. Row 0 writes every
        // line buffer entry that a random frame can reach, so later register changes within
        // a frame can never read one that was not written. Row 1 yields a segment for most
        // pixels, and the receiver holds off while it streams in.
        write_reg(CFG_THRESHOLD, $urandom_range(60, 190));
        write_reg(CFG_CELL_STEP, 1);
        write_reg(CFG_IMAGE_WIDTH, FILL_ROW);
        write_reg(CFG_IMAGE_HEIGHT, 2);
        for (int i = 0; i < 2 * FILL_ROW; i++) begin
            if (i == FILL_ROW + 8) squeeze_request = 1'b1;
            send_pixel(random_pixel(i == 0));
        end

        // Random phases. Each one rewrites some registers while the block is at rest, then
        // streams pixels that either start a new frame or carry on the current one, so
        // counters also meet sizes and steps that changed under them.
        while (random_count < RANDOM_PIXELS) begin
            settle();
            sender_calm   = ($urandom_range(0, 3) == 0);
            receiver_calm = ($urandom_range(0, 3) == 0);
            case (phases)
                0: begin
                    write_reg(CFG_THRESHOLD, 0);
                    write_reg(CFG_CELL_STEP, 16);
                end
                1: begin
                    write_reg(CFG_THRESHOLD, 255);
                    write_reg(CFG_CELL_STEP, 31);
                end
                default: begin
                    if ($urandom_range(0, 1))
                        write_reg(CFG_THRESHOLD, $urandom_range(0, 9) == 0 ?
                                  255 * $urandom_range(0, 1) : $urandom_range(0, 255));
                    if ($urandom_range(0, 1))
                        case ($urandom_range(0, 9))
                            0:       write_reg(CFG_CELL_STEP, 0);
                            1:       write_reg(CFG_CELL_STEP, 16);
                            2:       write_reg(CFG_CELL_STEP, $urandom_range(17, 31));
                            default: write_reg(CFG_CELL_STEP, $urandom_range(1, 4));
                        endcase
                end
            endcase
            if ($urandom_range(0, 1)) write_reg(CFG_IMAGE_WIDTH, pick_size());
            if ($urandom_range(0, 1)) write_reg(CFG_IMAGE_HEIGHT, pick_size());

            carry_on = ($urandom_range(0, 2) == 0);
            length   = $urandom_range(20, 100);
            for (int i = 0; i < length; i++) begin
                send_pixel(random_pixel((i == 0 && !carry_on) || $urandom_range(0, 79) == 0));
                random_count++;
            end
            phases++;
        end

        // Wind down: wait for every predicted segment, then watch for strays.
        sender_calm   = 1'b0;
        pixel_valid  <= 1'b0;
        while (sb.pending_segments.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d segment beats from %0d pixel beats, %0d of them over %0d random settings.",
                 sb.segments_checked, sb.pixels_noted, random_count, phases);
        $display("Corner codes reached (bit per code): %b; long receiver hold-off done: %0d.",
                 sb.codes_seen, squeeze_done);
        if (sb.failures == 0) begin
            $display("SUCCESS");
        end
        else begin
            $display("%0d segment beats were wrong or unexpected", sb.failures);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
